// ===== hw/rtl/typed_operand_stack_frame_defines.svh =====
// Assertion macros for the typed operand stack frame.
`ifndef TYPED_OPERAND_STACK_FRAME_DEFINES_SVH
`define TYPED_OPERAND_STACK_FRAME_DEFINES_SVH
`ifndef ASSERT_OFF
`define TOSF_ASSERT(lbl, expr) lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
  else $error("tosf assertion failed");
`define TOSF_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
  disable iff (rst) (pre) |=> (post)) else $error("tosf assertion failed");
`else
`define TOSF_ASSERT(lbl, expr)
`define TOSF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/tosf_pkg.sv =====
`timescale 1ns / 1ps
package tosf_pkg;
  localparam int STACK_DEPTH = 256;
  localparam int LOCAL_DEPTH = 256;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TOPW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;

  typedef enum logic [3:0] {
    K_PUSH = 4'd0, K_POP = 4'd1, K_POP_RELEASE = 4'd2, K_POP_ANY = 4'd3,
    K_DUP = 4'd4, K_DUP2 = 4'd5, K_DUP_X1 = 4'd6, K_SWAP = 4'd7,
    K_PEEK = 4'd8, K_LOAD_LOCAL = 4'd9, K_STORE_LOCAL = 4'd10, K_INC_LOCAL = 4'd11
  } kind_t;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_LONG = 2'd1;
  localparam logic [1:0] TAG_HANDLE = 2'd2;
  localparam logic [1:0] TAG_REF = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OVER = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_TYPE = 3'd3;
  localparam logic [2:0] ST_BOUNDS = 3'd4;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic CFG_STACK_LIMIT = 1'b0;
  localparam logic CFG_LOCAL_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  tag;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  tag;
    logic [2:0]  status;
    logic [1:0]  found;
    logic [1:0]  act;
    logic [63:0] target;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic       capture;
    logic       rd_first;
    logic       rd_second;
    logic       exec;
    logic       wr;
    logic [1:0] wr_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic            out_busy;
    logic [1:0]      wr_n;
    logic [TOPW-1:0] top;
  } ctl_stat_t;
endpackage

// ===== hw/rtl/tosf_op_if.sv =====
`timescale 1ns / 1ps
interface tosf_op_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  kind;
  logic        [1:0]  operand_tag;
  logic signed [63:0] operand_value;
  logic        [7:0]  slot_index;
  logic signed [15:0] step_amount;
  modport source (output valid, kind, operand_tag, operand_value, slot_index, step_amount,
                  input ready);
  modport sink (input valid, kind, operand_tag, operand_value, slot_index, step_amount,
                output ready);
endinterface

// ===== hw/rtl/tosf_res_if.sv =====
`timescale 1ns / 1ps
interface tosf_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic        [1:0]  result_tag;
  logic        [2:0]  status;
  logic        [1:0]  found_tag;
  logic        [1:0]  ref_action;
  logic signed [63:0] ref_target;
  logic               last;
  modport source (output valid, result_value, result_tag, status, found_tag, ref_action,
                  ref_target, last, input ready);
  modport sink (input valid, result_value, result_tag, status, found_tag, ref_action,
                ref_target, last, output ready);
endinterface

// ===== hw/rtl/tosf_cfg_if.sv =====
`timescale 1ns / 1ps
interface tosf_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/typed_operand_stack_frame.sv =====
`timescale 1ns / 1ps
// Typed operand stack and local store of one frame. An operation steps through
// accept, two registered reads of the single-port stack memory (top and next
// below, or the peeked entry), execute, then a first write state that also
// covers an operation with no stack write, and one more write state for each
// stack write beyond the first (up to three writes). Execute waits while the
// one- or two-item result buffer still holds the previous operation's
// transactions. Local tags read as none until first written; limits are
// written on the cfg channel.
`include "typed_operand_stack_frame_defines.svh"
module typed_operand_stack_frame import tosf_pkg::*; (
  input logic clk,
  input logic rst,
  tosf_op_if.sink    op,
  tosf_res_if.source res,
  tosf_cfg_if.sink   cfg
);
  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  res_item_t item;

  assign cfg.ready = 1'b1;

  tosf_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(op.valid), .in_ready(op.ready), .stat(stat), .cmd(cmd)
  );

  tosf_datapath u_dp (
    .clk(clk), .rst(rst),
    .in_kind(op.kind), .in_tag(op.operand_tag), .in_value(op.operand_value),
    .in_slot(op.slot_index), .in_step(op.step_amount),
    .cfg_fire(cfg.valid && cfg.ready), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .cmd(cmd), .stat(stat), .res_item(item), .res_valid(res.valid), .res_ready(res.ready)
  );

  assign res.result_value = item.value;
  assign res.result_tag = item.tag;
  assign res.status = item.status;
  assign res.found_tag = item.found;
  assign res.ref_action = item.act;
  assign res.ref_target = item.target;
  assign res.last = item.last;

  `TOSF_ASSERT(a_top_in_range, stat.top <= TOPW'(STACK_DEPTH))
  `TOSF_ASSERT_NEXT(a_exec_shows_result, cmd.exec, res.valid)
  `TOSF_ASSERT_NEXT(a_one_op_at_a_time, op.valid && op.ready, !op.ready)
endmodule

// ===== hw/rtl/tosf_datapath.sv =====
`timescale 1ns / 1ps
module tosf_datapath import tosf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  in_kind,
  input  logic [1:0]  in_tag,
  input  logic [63:0] in_value,
  input  logic [7:0]  in_slot,
  input  logic [15:0] in_step,
  input  logic        cfg_fire,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  output res_item_t   res_item,
  output logic        res_valid,
  input  logic        res_ready
);
  typedef enum logic [1:0] {SRC_OPND, SRC_A, SRC_B} src_t;

  logic [3:0]  kind_r;
  logic [1:0]  tag_r;
  logic [63:0] val_r;
  logic [7:0]  slot_r;
  logic [15:0] step_r;
  logic [8:0]  stack_limit;
  logic [8:0]  local_limit;
  logic [TOPW-1:0] top;
  entry_t stack_mem [STACK_DEPTH];
  entry_t local_mem [LOCAL_DEPTH];
  logic [LOCAL_DEPTH-1:0] lvalid;
  entry_t a_r;
  entry_t stack_rd;
  entry_t local_rd;
  logic   local_rd_ok;
  logic [SAW-1:0] wr_base;
  logic [1:0]     wr_n_r;
  res_item_t item0;
  res_item_t item1;
  logic v0;
  logic v1;

  logic [16:0] t17;
  logic [16:0] slim;
  logic [16:0] llim;
  logic [1:0]  ltag;
  logic [1:0]  h;
  logic [2:0]  st;
  logic [63:0] rv;
  logic [1:0]  rt;
  logic [1:0]  fd;
  logic        e0en;
  logic        e1en;
  logic [1:0]  e0a;
  logic [1:0]  e1a;
  logic [63:0] e0t;
  logic [63:0] e1t;
  logic        ev0;
  logic        ev1;
  logic [TOPW-1:0] top_next;
  logic [1:0]  wn;
  logic [SAW-1:0] base;
  logic        lwe;
  entry_t      lwd;
  logic [SAW-1:0] s_raddr;
  logic [TOPW-1:0] peek_pos;
  logic [SAW-1:0] s_waddr;
  entry_t      s_wdata;
  src_t        wsrc;
  logic [LAW-1:0] laddr;

  assign t17 = 17'(top);
  assign slim = (17'(stack_limit) > 17'(STACK_DEPTH)) ? 17'(STACK_DEPTH) : 17'(stack_limit);
  assign llim = (17'(local_limit) > 17'(LOCAL_DEPTH)) ? 17'(LOCAL_DEPTH) : 17'(local_limit);
  assign ltag = local_rd_ok ? local_rd.tag : TAG_NONE;
  assign laddr = LAW'(slot_r);
  assign peek_pos = top - TOPW'(1) - TOPW'(slot_r);

  always_comb begin
    if (cmd.rd_first) begin
      s_raddr = (kind_r == K_PEEK) ? SAW'(peek_pos) : SAW'(top - TOPW'(1));
    end else begin
      s_raddr = SAW'(top - TOPW'(2));
    end
  end

  always_comb begin
    unique case (kind_t'(kind_r))
      K_PUSH: wsrc = SRC_OPND;
      K_DUP: wsrc = SRC_A;
      K_DUP2: wsrc = (cmd.wr_idx == 2'd0) ? SRC_B : SRC_A;
      default: wsrc = (cmd.wr_idx == 2'd1) ? SRC_B : SRC_A;
    endcase
    case (wsrc)
      SRC_OPND: s_wdata = '{tag: tag_r, value: val_r};
      SRC_B: s_wdata = stack_rd;
      default: s_wdata = a_r;
    endcase
    s_waddr = wr_base + SAW'(cmd.wr_idx);
  end

  always_comb begin
    st = ST_OK;
    rv = '0;
    rt = TAG_NONE;
    fd = TAG_NONE;
    e0en = 1'b0;
    e1en = 1'b0;
    e0a = ACT_NONE;
    e1a = ACT_NONE;
    e0t = '0;
    e1t = '0;
    top_next = top;
    wn = 2'd0;
    base = SAW'(top);
    lwe = 1'b0;
    lwd = '{tag: tag_r, value: val_r};
    h = TAG_NONE;
    case (kind_r)
      K_PUSH: begin
        if (t17 >= slim) st = ST_OVER;
        else if (tag_r == TAG_NONE) st = ST_TYPE;
        else begin
          top_next = top + TOPW'(1);
          wn = 2'd1;
          e0en = (tag_r == TAG_REF);
          e0a = ACT_ADD;
          e0t = val_r;
        end
      end
      K_POP, K_POP_RELEASE, K_POP_ANY: begin
        h = (kind_r == K_POP) ? tag_r : TAG_REF;
        if (t17 < 17'd1) st = ST_UNDER;
        else if (kind_r != K_POP_ANY && (h == TAG_NONE || a_r.tag != h)) begin
          st = ST_TYPE;
          fd = a_r.tag;
        end else begin
          top_next = top - TOPW'(1);
          rv = a_r.value;
          rt = a_r.tag;
          e0en = (kind_r != K_POP) && (a_r.tag == TAG_REF);
          e0a = ACT_REMOVE;
          e0t = a_r.value;
        end
      end
      K_DUP: begin
        if (t17 < 17'd1) st = ST_UNDER;
        else if (t17 >= slim) st = ST_OVER;
        else begin
          top_next = top + TOPW'(1);
          wn = 2'd1;
          e0en = (a_r.tag == TAG_REF);
          e0a = ACT_ADD;
          e0t = a_r.value;
        end
      end
      K_DUP2: begin
        if (t17 < 17'd2) st = ST_UNDER;
        else if (t17 + 17'd2 > slim) st = ST_OVER;
        else begin
          top_next = top + TOPW'(2);
          wn = 2'd2;
          e0en = (stack_rd.tag == TAG_REF);
          e0a = ACT_ADD;
          e0t = stack_rd.value;
          e1en = (a_r.tag == TAG_REF);
          e1a = ACT_ADD;
          e1t = a_r.value;
        end
      end
      K_DUP_X1: begin
        if (t17 < 17'd2) st = ST_UNDER;
        else if (t17 + 17'd1 > slim) st = ST_OVER;
        else begin
          top_next = top + TOPW'(1);
          wn = 2'd3;
          base = SAW'(top - TOPW'(2));
          e0en = (a_r.tag == TAG_REF);
          e0a = ACT_ADD;
          e0t = a_r.value;
        end
      end
      K_SWAP: begin
        if (t17 < 17'd2) st = ST_UNDER;
        else begin
          wn = 2'd2;
          base = SAW'(top - TOPW'(2));
        end
      end
      K_PEEK: begin
        if (17'(slot_r) >= t17) st = ST_UNDER;
        else begin
          rv = a_r.value;
          rt = a_r.tag;
        end
      end
      K_LOAD_LOCAL, K_INC_LOCAL: begin
        h = (kind_r == K_LOAD_LOCAL) ? tag_r : TAG_LONG;
        if (17'(slot_r) >= llim) st = ST_BOUNDS;
        else if (h == TAG_NONE || ltag != h) begin
          st = ST_TYPE;
          fd = ltag;
        end else if (kind_r == K_LOAD_LOCAL) begin
          rv = local_rd.value;
          rt = ltag;
        end else begin
          lwe = 1'b1;
          lwd = '{tag: ltag, value: local_rd.value + {{48{step_r[15]}}, step_r}};
        end
      end
      K_STORE_LOCAL: begin
        if (17'(slot_r) >= llim) st = ST_BOUNDS;
        else if (tag_r == TAG_NONE) st = ST_TYPE;
        else begin
          lwe = 1'b1;
          e0en = (ltag == TAG_REF);
          e0a = ACT_REMOVE;
          e0t = local_rd.value;
          e1en = (tag_r == TAG_REF);
          e1a = ACT_ADD;
          e1t = val_r;
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign ev0 = e0en && (e0t != '0);
  assign ev1 = e1en && (e1t != '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      tag_r <= in_tag;
      val_r <= in_value;
      slot_r <= in_slot;
      step_r <= in_step;
    end
    if (cmd.rd_first || cmd.rd_second) stack_rd <= stack_mem[s_raddr];
    if (cmd.rd_second) a_r <= stack_rd;
    if (cmd.rd_first) begin
      local_rd <= local_mem[laddr];
    end
    if (cmd.wr) stack_mem[s_waddr] <= s_wdata;
    if (cmd.exec && lwe) local_mem[laddr] <= lwd;
    if (cmd.exec) begin
      wr_base <= base;
      item0 <= '{value: rv, tag: rt, status: st, found: fd,
                 act: ev0 ? e0a : (ev1 ? e1a : ACT_NONE),
                 target: ev0 ? e0t : (ev1 ? e1t : '0), last: !(ev0 && ev1)};
      item1 <= '{value: '0, tag: TAG_NONE, status: st, found: TAG_NONE,
                 act: e1a, target: e1t, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= '0;
      local_limit <= '0;
      top <= '0;
      lvalid <= '0;
      local_rd_ok <= 1'b0;
      wr_n_r <= 2'd0;
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == CFG_STACK_LIMIT) stack_limit <= cfg_data;
        else local_limit <= cfg_data;
      end
      if (cmd.rd_first) local_rd_ok <= lvalid[laddr];
      if (cmd.exec) begin
        top <= top_next;
        wr_n_r <= wn;
        if (lwe) lvalid[laddr] <= 1'b1;
        v0 <= 1'b1;
        v1 <= ev0 && ev1;
      end else if (res_ready) begin
        if (v0) v0 <= 1'b0;
        else v1 <= 1'b0;
      end
    end
  end

  assign res_item = v0 ? item0 : item1;
  assign res_valid = v0 || v1;
  assign stat = '{out_busy: v0 || v1, wr_n: wr_n_r, top: top};
endmodule

// ===== hw/rtl/tosf_controller.sv =====
`timescale 1ns / 1ps
module tosf_controller import tosf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RDA = 7'b0000010, S_RDB = 7'b0000100, S_EXEC = 7'b0001000,
    S_W0 = 7'b0010000, S_W1 = 7'b0100000, S_W2 = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_RDA;
      end
      S_RDA: begin
        cmd.rd_first = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_second = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec = 1'b1;
          state_next = S_W0;
        end
      end
      S_W0: begin
        cmd.wr = (stat.wr_n > 2'd0);
        cmd.wr_idx = 2'd0;
        state_next = (stat.wr_n > 2'd1) ? S_W1 : S_IDLE;
      end
      S_W1: begin
        cmd.wr = 1'b1;
        cmd.wr_idx = 2'd1;
        state_next = (stat.wr_n > 2'd2) ? S_W2 : S_IDLE;
      end
      S_W2: begin
        cmd.wr = 1'b1;
        cmd.wr_idx = 2'd2;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== tb/sv/tosf_tb_pkg.sv =====
`timescale 1ns / 1ps
package tosf_tb_pkg;
  import tosf_pkg::*;

  typedef struct {
    logic [3:0]  kind;
    logic [1:0]  tag;
    logic [63:0] value;
    logic [7:0]  slot;
    logic [15:0] step;
  } frame_op_t;
endpackage

// ===== tb/sv/tb_typed_operand_stack_frame.sv =====
`timescale 1ns / 1ps
module tb_typed_operand_stack_frame;
  import tosf_pkg::*;
  import tosf_tb_pkg::*;

  logic clk;
  logic rst;

  tosf_op_if  op ();
  tosf_res_if res ();
  tosf_cfg_if cfg ();

  typed_operand_stack_frame DUT (.clk(clk), .rst(rst), .op(op), .res(res), .cfg(cfg));

  frame_op_t   pending_ops[$];
  res_item_t   expected_results[$];
  logic [63:0] model_values[STACK_DEPTH];
  logic [1:0]  model_tags[STACK_DEPTH];
  int          model_top;
  logic [63:0] model_lvalues[LOCAL_DEPTH];
  logic [1:0]  model_ltags[LOCAL_DEPTH];
  int          model_slimit;
  int          model_llimit;
  int          mismatches;
  bit          ops_done;
  int          op_gap;
  int          res_gap;
  int          results_seen;
  bit          op_accepted;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void predict_frame_op(input frame_op_t o);
    res_item_t   main;
    res_item_t   second;
    int          n_events;
    int          slim;
    int          llim;
    int          t;
    logic [63:0] v;
    logic [63:0] w;
    logic [1:0]  g;
    logic [1:0]  h;
    logic [2:0]  st;
    logic [1:0]  acts[2];
    logic [63:0] tgts[2];
    main = '0;
    second = '0;
    n_events = 0;
    slim = model_slimit > STACK_DEPTH ? STACK_DEPTH : model_slimit;
    llim = model_llimit > LOCAL_DEPTH ? LOCAL_DEPTH : model_llimit;
    t = model_top;
    st = ST_OK;
    case (o.kind)
      K_PUSH: begin
        if (t >= slim) st = ST_OVER;
        else if (o.tag == TAG_NONE) st = ST_TYPE;
        else begin
          model_values[t] = o.value;
          model_tags[t] = o.tag;
          model_top = t + 1;
          if (o.tag == TAG_REF && o.value != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = o.value; n_events++;
          end
        end
      end
      K_POP, K_POP_RELEASE, K_POP_ANY: begin
        if (t < 1) st = ST_UNDER;
        else begin
          g = model_tags[t-1];
          v = model_values[t-1];
          h = o.kind == K_POP ? o.tag : TAG_REF;
          if (o.kind != K_POP_ANY && (h == TAG_NONE || g != h)) begin
            st = ST_TYPE; main.found = g;
          end else begin
            model_top = t - 1;
            main.value = v;
            main.tag = g;
            if (o.kind != K_POP && g == TAG_REF && v != 0) begin
              acts[n_events] = ACT_REMOVE; tgts[n_events] = v; n_events++;
            end
          end
        end
      end
      K_DUP: begin
        if (t < 1) st = ST_UNDER;
        else if (t >= slim) st = ST_OVER;
        else begin
          g = model_tags[t-1]; v = model_values[t-1];
          model_values[t] = v; model_tags[t] = g;
          model_top = t + 1;
          if (g == TAG_REF && v != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = v; n_events++;
          end
        end
      end
      K_DUP2: begin
        if (t < 2) st = ST_UNDER;
        else if (t + 2 > slim) st = ST_OVER;
        else begin
          v = model_values[t-2]; g = model_tags[t-2];
          w = model_values[t-1]; h = model_tags[t-1];
          model_values[t] = v; model_tags[t] = g;
          model_values[t+1] = w; model_tags[t+1] = h;
          model_top = t + 2;
          if (g == TAG_REF && v != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = v; n_events++;
          end
          if (h == TAG_REF && w != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = w; n_events++;
          end
        end
      end
      K_DUP_X1: begin
        if (t < 2) st = ST_UNDER;
        else if (t + 1 > slim) st = ST_OVER;
        else begin
          v = model_values[t-2]; g = model_tags[t-2];
          w = model_values[t-1]; h = model_tags[t-1];
          model_values[t-2] = w; model_tags[t-2] = h;
          model_values[t-1] = v; model_tags[t-1] = g;
          model_values[t] = w; model_tags[t] = h;
          model_top = t + 1;
          if (h == TAG_REF && w != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = w; n_events++;
          end
        end
      end
      K_SWAP: begin
        if (t < 2) st = ST_UNDER;
        else begin
          v = model_values[t-2]; g = model_tags[t-2];
          model_values[t-2] = model_values[t-1]; model_tags[t-2] = model_tags[t-1];
          model_values[t-1] = v; model_tags[t-1] = g;
        end
      end
      K_PEEK: begin
        if (int'(o.slot) >= t) st = ST_UNDER;
        else begin
          main.value = model_values[t-1-o.slot];
          main.tag = model_tags[t-1-o.slot];
        end
      end
      K_LOAD_LOCAL, K_INC_LOCAL: begin
        if (int'(o.slot) >= llim) st = ST_BOUNDS;
        else begin
          g = model_ltags[o.slot];
          h = o.kind == K_LOAD_LOCAL ? o.tag : TAG_LONG;
          if (h == TAG_NONE || g != h) begin
            st = ST_TYPE; main.found = g;
          end else if (o.kind == K_LOAD_LOCAL) begin
            main.value = model_lvalues[o.slot];
            main.tag = g;
          end else begin
            model_lvalues[o.slot] = model_lvalues[o.slot] + {{48{o.step[15]}}, o.step};
          end
        end
      end
      K_STORE_LOCAL: begin
        if (int'(o.slot) >= llim) st = ST_BOUNDS;
        else if (o.tag == TAG_NONE) st = ST_TYPE;
        else begin
          if (model_ltags[o.slot] == TAG_REF && model_lvalues[o.slot] != 0) begin
            acts[n_events] = ACT_REMOVE; tgts[n_events] = model_lvalues[o.slot];
            n_events++;
          end
          if (o.tag == TAG_REF && o.value != 0) begin
            acts[n_events] = ACT_ADD; tgts[n_events] = o.value; n_events++;
          end
          model_lvalues[o.slot] = o.value;
          model_ltags[o.slot] = o.tag;
        end
      end
      default: ;
    endcase
    main.status = st;
    if (n_events > 0) begin
      main.act = acts[0]; main.target = tgts[0];
    end
    if (n_events > 1) begin
      second.status = st; second.act = acts[1]; second.target = tgts[1];
      second.last = 1'b1;
      expected_results.push_back(main);
      expected_results.push_back(second);
    end else begin
      main.last = 1'b1;
      expected_results.push_back(main);
    end
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic frame_op_t make_op(input int k, input int tg, input logic [63:0] v,
                                        input int sl, input int sp);
    frame_op_t o;
    o.kind = 4'(k); o.tag = 2'(tg); o.value = v; o.slot = 8'(sl); o.step = 16'(sp);
    return o;
  endfunction

  task automatic write_limit(input logic idx, input int val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= 9'(val);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_STACK_LIMIT) model_slimit = val;
    else model_llimit = val;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || op.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int        k;
    int        lim;
    frame_op_t o;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) k = K_PUSH;
      else if (k < 95) k = $urandom_range(1, 11);
      else k = $urandom_range(12, 15);
      o = make_op(k, $urandom_range(0, 99) < 5 ? 0 : $urandom_range(1, 3), rand_value(),
                  $urandom_range(0, 99) < 80 ? $urandom_range(0, 15) : $urandom_range(0, 255),
                  $urandom());
      pending_ops.push_back(o);
    end
  endtask

  initial begin
    rst = 1'b1;
    op.valid = 1'b0; op.kind = '0; op.operand_tag = '0; op.operand_value = '0;
    op.slot_index = '0; op.step_amount = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = 1'b0; cfg.data = '0;
    model_top = 0; model_slimit = 0; model_llimit = 0;
    mismatches = 0; ops_done = 1'b0; results_seen = 0;
    for (int i = 0; i < LOCAL_DEPTH; i++) begin
      model_ltags[i] = TAG_NONE; model_lvalues[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    pending_ops.push_back(make_op(K_PUSH, TAG_LONG, 64'd1, 0, 0));
    pending_ops.push_back(make_op(K_POP, TAG_LONG, 0, 0, 0));
    drain();
    write_limit(CFG_STACK_LIMIT, 4);
    write_limit(CFG_LOCAL_LIMIT, 256);
    pending_ops.push_back(make_op(K_POP_ANY, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_PEEK, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_PUSH, TAG_NONE, 64'd5, 0, 0));
    pending_ops.push_back(make_op(K_PUSH, TAG_REF, 64'h8000_0000_0000_0000, 0, 0));
    pending_ops.push_back(make_op(K_PUSH, TAG_REF, 64'd0, 0, 0));
    pending_ops.push_back(make_op(K_DUP2, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_PUSH, TAG_LONG, '1, 0, 0));
    pending_ops.push_back(make_op(K_POP, TAG_HANDLE, 0, 0, 0));
    pending_ops.push_back(make_op(K_PEEK, TAG_LONG, 0, 3, 0));
    pending_ops.push_back(make_op(K_PEEK, TAG_LONG, 0, 255, 0));
    pending_ops.push_back(make_op(K_POP_RELEASE, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_DUP_X1, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_SWAP, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_DUP, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_POP_RELEASE, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_LOAD_LOCAL, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_STORE_LOCAL, TAG_REF, 64'h1234, 255, 0));
    pending_ops.push_back(make_op(K_STORE_LOCAL, TAG_REF, 64'h5678, 255, 0));
    pending_ops.push_back(make_op(K_STORE_LOCAL, TAG_LONG, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0));
    pending_ops.push_back(make_op(K_INC_LOCAL, TAG_LONG, 0, 0, 16'h0001));
    pending_ops.push_back(make_op(K_INC_LOCAL, TAG_LONG, 0, 0, 16'h8000));
    pending_ops.push_back(make_op(K_LOAD_LOCAL, TAG_LONG, 0, 0, 0));
    pending_ops.push_back(make_op(K_LOAD_LOCAL, TAG_NONE, 0, 0, 0));
    pending_ops.push_back(make_op(K_INC_LOCAL, TAG_LONG, 0, 255, 16'h7FFF));
    pending_ops.push_back(make_op(4'd15, TAG_REF, '1, 255, 16'hFFFF));
    drain();
    write_limit(CFG_LOCAL_LIMIT, 0);
    pending_ops.push_back(make_op(K_LOAD_LOCAL, TAG_LONG, 0, 0, 0));
    drain();
    write_limit(CFG_STACK_LIMIT, 1);
    pending_ops.push_back(make_op(K_PUSH, TAG_LONG, 1, 0, 0));
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_limit(CFG_STACK_LIMIT, 16); write_limit(CFG_LOCAL_LIMIT, 16); end
        1: begin write_limit(CFG_STACK_LIMIT, 511); write_limit(CFG_LOCAL_LIMIT, 511); end
        2: begin write_limit(CFG_STACK_LIMIT, 8); write_limit(CFG_LOCAL_LIMIT, 4); end
        3: begin write_limit(CFG_STACK_LIMIT, 256); write_limit(CFG_LOCAL_LIMIT, 256); end
        4: begin write_limit(CFG_STACK_LIMIT, 0); write_limit(CFG_LOCAL_LIMIT, 1); end
        default: begin write_limit(CFG_STACK_LIMIT, 32); write_limit(CFG_LOCAL_LIMIT, 257); end
      endcase
      queue_random(125);
      drain();
    end
    ops_done = 1'b1;
    if (mismatches == 0) $display("typed_operand_stack_frame regression: pass");
    else $display("typed_operand_stack_frame regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("typed_operand_stack_frame regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      op_gap <= 0;
      op_accepted <= 1'b0;
    end else if (op.valid && op.ready) begin
      predict_frame_op(pending_ops.pop_front());
      op_accepted <= 1'b1;
      op_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    end else begin
      op_accepted <= 1'b0;
      if (!op.valid && op_gap > 0) op_gap <= op_gap - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!op.valid || op_accepted) begin
        if (pending_ops.size() != 0 && op_gap == 0 && !cfg.valid) begin
          op.valid <= 1'b1;
          op.kind <= pending_ops[0].kind;
          op.operand_tag <= pending_ops[0].tag;
          op.operand_value <= pending_ops[0].value;
          op.slot_index <= pending_ops[0].slot;
          op.step_amount <= pending_ops[0].step;
        end else begin
          op.valid <= 1'b0;
        end
      end
      if (res_gap == 0) res.ready <= 1'b1;
      else res.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      res_gap <= 0;
    end else if (res.valid && res.ready) begin
      res_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        want = expected_results.pop_front();
        if (res.result_value !== want.value || res.result_tag !== want.tag ||
            res.status !== want.status || res.found_tag !== want.found ||
            res.ref_action !== want.act || res.ref_target !== want.target ||
            res.last !== want.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp %h %0d %0d %0d %0d %h %0d got %h %0d %0d %0d %0d %h %0d",
                     want.value, want.tag, want.status, want.found, want.act, want.target,
                     want.last, res.result_value, res.result_tag, res.status,
                     res.found_tag, res.ref_action, res.ref_target, res.last);
        end
      end
    end else if (res_gap > 0) begin
      res_gap <= res_gap - 1;
    end
  end
endmodule
